// ===== hw/rtl/http_uri_stream_parser_defines.svh =====
// Assertion macros for the HTTP URI stream parser.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef HTTP_URI_STREAM_PARSER_DEFINES_SVH
`define HTTP_URI_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH
// Check that prop holds at every edge outside reset.
`define HURP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hurp assertion failed");
// Check that cond holds in the cycle after trig.
`define HURP_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("hurp assertion failed");
`else
`define HURP_ASSERT(lbl, clk, rst, prop)
`define HURP_ASSERT_NEXT(lbl, clk, rst, trig, cond)
`endif

`endif

// ===== hw/rtl/hurp_pkg.sv =====
// Types, codes and constants shared by the HTTP URI stream parser.
// No dependencies.
package hurp_pkg;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_PREFIX   = 3'd1,
    PH_HOST     = 3'd2,
    PH_PORT     = 3'd3,
    PH_PATH     = 3'd4,
    PH_PATHFORM = 3'd5,
    PH_BAD      = 3'd6,
    PH_OVER     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_OTHER = 2'd0,
    ROLE_HOST  = 2'd1,
    ROLE_PATH  = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    ST_ABS_OK     = 2'd0,
    ST_PATH_OK    = 2'd1,
    ST_BAD_PREFIX = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  localparam int unsigned PortAccW = 17;
  localparam int unsigned PortW    = 16;

  localparam logic [PortW-1:0]    PORT_DEFAULT = 16'd80;
  localparam logic [PortAccW-1:0] PORT_MAX     = 17'd65535;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_S     = 8'h73;

  // Parser state carried from one request to the next
  typedef struct packed {
    phase_t              phase;
    logic [3:0]          match_pos;
    logic [PortAccW-1:0] port_acc;
    logic                path_seen;
  } hurp_state_t;

  // One result item
  typedef struct packed {
    logic [7:0]       char_out;
    role_t            char_role;
    logic             done_res;
    status_t          status;
    logic [PortW-1:0] port;
    logic             default_path;
  } hurp_result_t;

  // Expected scheme character at a prefix position
  function automatic logic [7:0] scheme_char(input logic secure, input logic [2:0] idx);
    logic [7:0] ch;
    if (secure) begin
      case (idx)
        3'd0:    ch = 8'h68; // h
        3'd1:    ch = 8'h74; // t
        3'd2:    ch = 8'h74; // t
        3'd3:    ch = 8'h70; // p
        3'd4:    ch = 8'h73; // s
        3'd5:    ch = 8'h3A; // :
        3'd6:    ch = 8'h2F; // /
        default: ch = 8'h2F; // /
      endcase
    end else begin
      case (idx)
        3'd0:    ch = 8'h68;
        3'd1:    ch = 8'h74;
        3'd2:    ch = 8'h74;
        3'd3:    ch = 8'h70;
        3'd4:    ch = 8'h3A;
        3'd5:    ch = 8'h2F;
        3'd6:    ch = 8'h2F;
        default: ch = 8'h68; // position wraps for the plain scheme
      endcase
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/hurp_step.sv =====
// Per-character parse step: next parser state and the result item.
// Depends on hurp_pkg.
module hurp_step import hurp_pkg::*; (
  input  hurp_state_t  cur,
  input  logic [7:0]   char_in,
  input  logic         end_of_uri,
  output hurp_state_t  nxt,
  output hurp_result_t res
);

  logic       pfx_sec;
  logic [2:0] pfx_idx;
  logic [7:0] want;
  logic       to_secure;
  logic       pfx_bad;
  logic       sec_n;
  logic [3:0] idx_inc;
  logic       pfx_done;
  logic       is_digit;
  logic [3:0] digit;
  logic [19:0] port_mul;
  logic       port_over;

  // Prefix matcher; the start phase matches from position zero
  always_comb begin
    pfx_sec   = (cur.phase == PH_START) ? 1'b0 : cur.match_pos[3];
    pfx_idx   = (cur.phase == PH_START) ? 3'd0 : cur.match_pos[2:0];
    want      = scheme_char(pfx_sec, pfx_idx);
    to_secure = !pfx_sec && (pfx_idx == 3'd4) && (char_in == CHAR_S);
    pfx_bad   = !to_secure && (char_in != want);
    sec_n     = pfx_sec | to_secure;
    idx_inc   = {1'b0, pfx_idx} + 4'd1;
    pfx_done  = idx_inc >= (sec_n ? 4'd8 : 4'd7);
  end

  // Port accumulator: acc * 10 + digit; an ASCII digit carries its value in the low nibble
  always_comb begin
    is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    digit     = char_in[3:0];
    port_mul  = {cur.port_acc, 3'b000} + {2'b00, cur.port_acc, 1'b0}
                + {16'd0, digit};
    port_over = port_mul > {3'd0, PORT_MAX};
  end

  // Next state
  always_comb begin
    nxt = cur;
    if (end_of_uri) begin
      nxt.phase     = PH_START;
      nxt.match_pos = 4'd0;
      nxt.port_acc  = '0;
      nxt.path_seen = 1'b0;
    end else begin
      case (cur.phase)
        PH_START, PH_PREFIX: begin
          if (cur.phase == PH_START && char_in == CHAR_SLASH) begin
            nxt.phase = PH_PATHFORM;
          end else if (pfx_bad) begin
            nxt.phase     = PH_BAD;
            nxt.match_pos = {pfx_sec, pfx_idx};
          end else if (pfx_done) begin
            nxt.phase     = PH_HOST;
            nxt.match_pos = 4'd0;
          end else begin
            nxt.phase     = PH_PREFIX;
            nxt.match_pos = {sec_n, idx_inc[2:0]};
          end
        end
        PH_HOST: begin
          if (char_in == CHAR_COLON) begin
            nxt.phase = PH_PORT;
          end else if (char_in == CHAR_SLASH) begin
            nxt.phase     = PH_PATH;
            nxt.path_seen = 1'b1;
          end
        end
        PH_PORT: begin
          if (is_digit) begin
            if (port_over) begin
              nxt.phase    = PH_OVER;
              nxt.port_acc = '0;
            end else begin
              nxt.port_acc = port_mul[PortAccW-1:0];
            end
          end else begin
            nxt.phase     = PH_PATH;
            nxt.path_seen = 1'b1;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  // Result item
  always_comb begin
    res = '{char_out: 8'd0, char_role: ROLE_OTHER, done_res: 1'b0,
            status: ST_ABS_OK, port: '0, default_path: 1'b0};
    if (end_of_uri) begin
      res.done_res = 1'b1;
      case (cur.phase)
        PH_HOST, PH_PORT, PH_PATH: begin
          res.status       = ST_ABS_OK;
          res.port         = (cur.port_acc == '0) ? PORT_DEFAULT : cur.port_acc[PortW-1:0];
          res.default_path = !cur.path_seen;
        end
        PH_PATHFORM: begin
          res.status = ST_PATH_OK;
          res.port   = PORT_DEFAULT;
        end
        PH_OVER: begin
          res.status = ST_OVERFLOW;
          res.port   = '0;
        end
        default: begin
          res.status = ST_BAD_PREFIX;
          res.port   = PORT_DEFAULT;
        end
      endcase
    end else begin
      res.char_out = char_in;
      case (cur.phase)
        PH_START: begin
          res.char_role = (char_in == CHAR_SLASH) ? ROLE_PATH : ROLE_OTHER;
        end
        PH_HOST: begin
          if (char_in == CHAR_COLON) begin
            res.char_role = ROLE_OTHER;
          end else if (char_in == CHAR_SLASH) begin
            res.char_role = ROLE_PATH;
          end else begin
            res.char_role = ROLE_HOST;
          end
        end
        PH_PORT: begin
          res.char_role = is_digit ? ROLE_OTHER : ROLE_PATH;
        end
        PH_PATH, PH_PATHFORM: begin
          res.char_role = ROLE_PATH;
        end
        default: begin
          res.char_role = ROLE_OTHER;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/hurp_outbuf.sv =====
// Result register with one skid entry; the input side stalls only while
// the skid entry is occupied. Depends on hurp_pkg.
module hurp_outbuf import hurp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  input  hurp_result_t up_data,
  output logic         up_stall,
  output logic         dn_valid,
  input  logic         dn_stall,
  output hurp_result_t dn_data
);

  logic         out_valid;
  hurp_result_t out_data;
  logic         skid_valid;
  hurp_result_t skid_data;
  logic         load_out;

  assign load_out = !out_valid || !dn_stall;
  assign up_stall = skid_valid;
  assign dn_valid = out_valid;
  assign dn_data  = out_data;

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || up_valid;
      skid_valid <= 1'b0;
    end else if (up_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload: skid drains first, else the new request lands directly
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (up_valid) begin
        out_data <= up_data;
      end
    end else if (up_valid && !skid_valid) begin
      skid_data <= up_data;
    end
  end

endmodule

// ===== hw/rtl/http_uri_stream_parser.sv =====
// Top level of the HTTP URI stream parser: parser state, step logic and
// result buffer. Depends on hurp_pkg, hurp_step, hurp_outbuf and the defines header.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | char_in, end_of_uri
//   res     | out       | res_valid/res_stall  | char_out, char_role, done_res,
//           |           |                      | status, port, default_path
//
// One request per cycle while req_stall is low; each result is registered.
// The parse step is a single combinational pass from parser state to result register.
// Reset is synchronous; parser state clears directly, with no clearing pass.
// A stalled result parks one more request in a skid entry; req_stall rises
// while that entry is occupied.
`include "http_uri_stream_parser_defines.svh"

module http_uri_stream_parser import hurp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_uri,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  char_out,
  output logic [1:0]  char_role,
  output logic        done_res,
  output logic [1:0]  status,
  output logic [15:0] port,
  output logic        default_path
);

  hurp_state_t  state;
  hurp_state_t  state_next;
  hurp_result_t step_res;
  hurp_result_t res_q;
  logic         accept;

  assign accept = req_valid && !req_stall;

  hurp_step u_step (
    .cur        (state),
    .char_in    (char_in),
    .end_of_uri (end_of_uri),
    .nxt        (state_next),
    .res        (step_res)
  );

  // Hold parser state until a request is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_START;
      state.match_pos <= 4'd0;
      state.port_acc  <= '0;
      state.path_seen <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  hurp_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_data  (step_res),
    .up_stall (req_stall),
    .dn_valid (res_valid),
    .dn_stall (res_stall),
    .dn_data  (res_q)
  );

  assign char_out     = res_q.char_out;
  assign char_role    = res_q.char_role;
  assign done_res     = res_q.done_res;
  assign status       = res_q.status;
  assign port         = res_q.port;
  assign default_path = res_q.default_path;

  // Checks
  `HURP_ASSERT_NEXT(a_end_clears, clk, rst, accept && end_of_uri, state.phase == PH_START && state.match_pos == 4'd0 && state.port_acc == '0)
  `HURP_ASSERT(a_stall_needs_full, clk, rst, !req_stall || res_valid)
  `HURP_ASSERT(a_port_in_range, clk, rst, state.port_acc[PortAccW-1] == 1'b0)
  `HURP_ASSERT(a_over_port_zero, clk, rst, !(res_valid && done_res && status == ST_OVERFLOW) || port == '0)

endmodule
